/* hw/rtl/vle64_pkg.sv */
`timescale 1ns / 1ps

package vle64_pkg;

    // Format selector bits.
    localparam int unsigned FMT_SIGNED_BIT = 0;
    localparam int unsigned FMT_V2_BIT     = 1;

    // Byte index of the ninth byte, which carries 8 data bits and no flag.
    localparam logic [3:0] LAST_BYTE_IDX = 4'd8;

    localparam logic [63:0] MAG_MSB_MASK = 64'h7fff_ffff_ffff_ffff;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] value;
    } vle_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } vle_out_t;

endpackage

/* hw/rtl/varint_encoder_64_top.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Payload
// s_        in         s_valid/s_ready   vle64_pkg::vle_in_t  (func, value)
// m_        out        m_valid/m_ready   vle64_pkg::vle_out_t (out_byte, last)
//
// An input beat passes an input register and a magnitude register, then a
// byte serializer that loads the sign-mapped value and emits one output beat
// per cycle while m_ready does not stall, 1 to 9 bytes per item; it takes a
// new item in the cycle its last byte moves to the output register. Reset
// (aresetn, synchronous) clears all valid bits. A stall on m_ready holds every
// stage; nothing is dropped or repeated.
module varint_encoder_64_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vle64_pkg::vle_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vle64_pkg::vle_out_t m_data
);

    // Stage 1: input register.
    logic               st1_valid_reg;
    vle64_pkg::vle_in_t st1_data_reg;
    logic               st1_ready;

    // Stage 2: magnitude.
    logic        st2_valid_reg;
    logic [63:0] st2_mag_reg;
    logic        st2_signed_reg;
    logic        st2_neg_reg;
    logic        st2_v2_reg;
    logic        st2_ready;

    // Serializer.
    logic        ser_valid_reg;
    logic [63:0] ser_rem_reg;
    logic [3:0]  ser_idx_reg;
    logic        ser_v2_reg;
    logic        ser_adv;
    logic        ser_free;
    logic        ser_cont;
    logic        ser_last;
    logic [7:0]  ser_byte;
    logic [63:0] ser_rem_next;
    logic [63:0] st2_rem;

    // Output register.
    logic                m_valid_reg;
    vle64_pkg::vle_out_t m_data_reg;

    logic        st1_signed;
    logic        st1_v2;
    logic        st1_neg;
    logic [63:0] st1_inv;
    logic [63:0] st1_mag;

    assign ser_adv   = ser_valid_reg && (!m_valid_reg || m_ready);
    assign ser_free  = !ser_valid_reg || (ser_adv && ser_last);
    assign st2_ready = !st2_valid_reg || ser_free;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_ready   = st1_ready;

    always_comb begin
        st1_signed = st1_data_reg.func[vle64_pkg::FMT_SIGNED_BIT];
        st1_v2     = st1_data_reg.func[vle64_pkg::FMT_V2_BIT];
        st1_neg    = st1_signed && st1_data_reg.value[63];
        st1_inv    = ~st1_data_reg.value;
        if (!st1_neg) begin
            st1_mag = st1_data_reg.value;
        end else if (st1_v2) begin
            st1_mag = st1_inv;
        end else begin
            st1_mag = (st1_inv + 64'd1) & vle64_pkg::MAG_MSB_MASK;
        end
    end

    // Sign at bit 6; magnitude bits 6 and up move up by one.
    always_comb begin
        if (st2_signed_reg) begin
            st2_rem = {st2_mag_reg[62:6], st2_neg_reg, st2_mag_reg[5:0]};
        end else begin
            st2_rem = st2_mag_reg;
        end
    end

    always_comb begin
        ser_cont     = (ser_idx_reg != vle64_pkg::LAST_BYTE_IDX) &&
                       (ser_rem_reg[63:7] != 57'd0);
        ser_last     = !ser_cont;
        ser_byte     = (ser_idx_reg == vle64_pkg::LAST_BYTE_IDX) ? ser_rem_reg[7:0]
                                                                 : {ser_cont, ser_rem_reg[6:0]};
        ser_rem_next = {7'd0, ser_rem_reg[63:7]} - {63'd0, ser_v2_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            ser_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_valid_reg <= s_valid;
            end
            if (st2_ready) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (ser_free) begin
                ser_valid_reg <= st2_valid_reg;
            end
            if (ser_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_ready) begin
            st1_data_reg <= s_data;
        end
        if (st2_ready) begin
            st2_mag_reg    <= st1_mag;
            st2_signed_reg <= st1_signed;
            st2_neg_reg    <= st1_neg;
            st2_v2_reg     <= st1_v2;
        end
        if (ser_free) begin
            ser_rem_reg <= st2_rem;
            ser_idx_reg <= 4'd0;
            ser_v2_reg  <= st2_v2_reg;
        end else if (ser_adv) begin
            ser_rem_reg <= ser_rem_next;
            ser_idx_reg <= ser_idx_reg + 4'd1;
        end
        if (ser_adv) begin
            m_data_reg.out_byte <= ser_byte;
            m_data_reg.last     <= ser_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The serializer never runs past the ninth byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> (ser_idx_reg <= vle64_pkg::LAST_BYTE_IDX))
        else $error("serializer byte index out of range");

    // The ninth byte always closes the item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_valid_reg && ser_idx_reg == vle64_pkg::LAST_BYTE_IDX) |-> ser_last)
        else $error("ninth byte not marked last");

    // A continuation byte keeps the same item and steps the index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_adv && !ser_last) |=>
            (ser_valid_reg && ser_idx_reg == $past(ser_idx_reg) + 4'd1))
        else $error("serializer lost its item mid-encoding");

    // A negative mark only comes from a signed format.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st2_valid_reg && !st2_signed_reg) |-> !st2_neg_reg)
        else $error("sign set on unsigned format");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    typedef enum logic [1:0] {
        FMT_UNSIGNED_V1 = 2'd0,
        FMT_SIGNED_V1   = 2'd1,
        FMT_UNSIGNED_V2 = 2'd2,
        FMT_SIGNED_V2   = 2'd3
    } varint_fmt_t;

    localparam int RANDOM_PER_PHASE = 75;
    localparam int DRAIN_CYCLES     = 20;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    vle64_pkg::vle_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    vle64_pkg::vle_out_t m_data;

    vle64_pkg::vle_in_t  pending_items[$];
    vle64_pkg::vle_out_t enc_bytes_due[$];
    int                  src_idle_pct   = 0;
    int                  sink_stall_pct = 0;
    int                  fail_count     = 0;
    logic                in_beat_taken  = 1'b0;

    varint_encoder_64_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Computes the byte sequence for one input beat and queues it.
    function automatic void predict_varint(input vle64_pkg::vle_in_t item);
        logic [63:0]         rem;
        logic [63:0]         mag;
        logic                neg;
        logic                v2;
        vle64_pkg::vle_out_t b;
        v2  = item.func[vle64_pkg::FMT_V2_BIT];
        rem = item.value;
        if (item.func[vle64_pkg::FMT_SIGNED_BIT]) begin
            neg = item.value[63];
            if (!neg)
                mag = item.value;
            else if (v2)
                mag = ~item.value;
            else
                mag = (~item.value + 64'd1) & vle64_pkg::MAG_MSB_MASK;
            // Sign goes to bit 6; magnitude bits above the low six shift up by one.
            rem = ({63'd0, neg} << 6) | ((mag & ~64'h3f) << 1) | (mag & 64'h3f);
        end
        for (int i = 0; i < 8; i++) begin
            b.out_byte = {1'b0, rem[6:0]};
            rem = rem >> 7;
            if (rem != 64'd0) begin
                b.out_byte[7] = 1'b1;
                b.last = 1'b0;
                enc_bytes_due.push_back(b);
                if (v2)
                    rem = rem - 64'd1;
            end else begin
                b.last = 1'b1;
                enc_bytes_due.push_back(b);
                return;
            end
        end
        b.out_byte = rem[7:0];
        b.last = 1'b1;
        enc_bytes_due.push_back(b);
    endfunction

    // Driver: inputs change on the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (!s_valid || in_beat_taken) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts on each accepted input beat and checks each output beat.
    always @(posedge aclk) begin
        vle64_pkg::vle_out_t exp_b;
        in_beat_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            predict_varint(s_data);
        if (aresetn && m_valid && m_ready) begin
            if (enc_bytes_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected beat: expected none, got byte %h last %b",
                         $time, m_data.out_byte, m_data.last);
            end else begin
                exp_b = enc_bytes_due.pop_front();
                if (m_data.out_byte !== exp_b.out_byte) begin
                    fail_count++;
                    $display("%0t: out_byte mismatch: expected %h, got %h",
                             $time, exp_b.out_byte, m_data.out_byte);
                end
                if (m_data.last !== exp_b.last) begin
                    fail_count++;
                    $display("%0t: last mismatch: expected %b, got %b",
                             $time, exp_b.last, m_data.last);
                end
            end
        end
    end

    initial begin
        logic [63:0]        corner_values [6];
        varint_fmt_t        fmts [4];
        vle64_pkg::vle_in_t item;
        int                 shift;

        corner_values = '{64'h0, 64'h7f, 64'h80, 64'hffff_ffff_ffff_ffff,
                          64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff};
        fmts = '{FMT_UNSIGNED_V1, FMT_SIGNED_V1, FMT_UNSIGNED_V2, FMT_SIGNED_V2};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Extremes of the value in every format.
        foreach (fmts[f])
            foreach (corner_values[k]) begin
                item.func  = fmts[f];
                item.value = corner_values[k];
                pending_items.push_back(item);
            end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Shifting a full random word spreads the encoded lengths;
                // inverting some gives small negatives for the signed formats.
                shift      = $urandom_range(0, 63);
                item.func  = 2'($urandom_range(0, 3));
                item.value = {$urandom, $urandom} >> shift;
                if ($urandom_range(0, 3) == 0)
                    item.value = ~item.value;
                pending_items.push_back(item);
            end
            while (pending_items.size() != 0 || s_valid || enc_bytes_due.size() != 0)
                @(posedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && enc_bytes_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
